@@ sv/lrupr_pkg.sv @@
// Shared types and constants for the LRU page replacement block.
package lrupr_pkg;

  // Fixed field widths of the transaction payloads
  localparam int PAGE_FIELD_W  = 16;
  localparam int COUNT_W       = 32;
  localparam int LIMIT_W       = 6;

  // Defaults for the top-level parameters
  localparam int MAX_FRAMES_DEF = 32;
  localparam int PAGE_BITS_DEF  = 16;

  // Frame limit after reset
  localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RST = 6'd32;

  // Saturation value of the fault counter
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [PAGE_FIELD_W-1:0] page_number;
    logic                    first_of_run;
  } lrupr_req_t;

  typedef struct packed {
    logic                    hit;
    logic [COUNT_W-1:0]      fault_count;
    logic                    evicted_valid;
    logic [PAGE_FIELD_W-1:0] evicted_page;
  } lrupr_rsp_t;

  // Control broadcast to every cell of the stack
  typedef struct packed {
    logic upd;         // update cycle of a transaction
    logic found;       // the key is resident somewhere in the stack
    logic miss_shift;  // miss that pushes the key in at the front
  } lrupr_cell_ctrl_t;

endpackage

@@ sv/lru_page_replacement.sv @@
// Top level of the LRU page replacement block: control, counters and cell row.
//
//  channel  signals                 accepted when
//  -------  ----------------------  ---------------------------------
//  input    start, busy, req        rising edge with start=1, busy=0
//  result   done, rsp               rising edge ending the done cycle
//  config   cfg_we, cfg_data        rising edge with cfg_we=1
//
// In each transaction the accept edge latches the request,
// the next edge compares the key in every cell, shifts the row and
// registers the result, with done high in the cycle after.
// busy is high for the one cycle between accept and update.
// The result cannot be stalled; a new request may be taken while done is high.
// Synchronous reset clears the control state and sets frame_limit to 32.
module lru_page_replacement
  import lrupr_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  lrupr_req_t         req,
  output logic               done,
  output lrupr_rsp_t         rsp,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_data
);

  localparam int OCC_W = $clog2(MAX_FRAMES + 1);
  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CMP_W = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;

  // Registers
  logic                 pend;
  logic [PAGE_BITS-1:0] key;
  logic                 first_q;
  logic [OCC_W-1:0]     occ;
  logic [COUNT_W-1:0]   faults;
  logic [LIMIT_W-1:0]   frame_limit;

  // Cell row wiring
  logic [PAGE_BITS-1:0] pages [MAX_FRAMES];
  logic [PAGE_BITS-1:0] lefts [MAX_FRAMES];
  logic                 seen  [MAX_FRAMES+1];
  lrupr_cell_ctrl_t     ctrl;

  logic [OCC_W-1:0]     occ_eff;
  logic [COUNT_W-1:0]   fault_base;
  logic [COUNT_W-1:0]   fault_new;
  logic [CMP_W-1:0]     lim;
  logic                 found;
  logic                 insert;
  logic                 evict;
  logic [OCC_W-1:0]     top;
  logic [OCC_W-1:0]     occ_last;
  logic [PAGE_BITS-1:0] victim;
  logic [OCC_W-1:0]     occ_next;
  lrupr_rsp_t           rsp_next;

  assign busy = pend;

  // Start of run drops the old stack and count
  assign occ_eff    = first_q ? '0 : occ;
  assign fault_base = first_q ? '0 : faults;

  // Limit above the row size acts as the row size
  assign lim = (CMP_W'(frame_limit) > CMP_W'(MAX_FRAMES)) ?
               CMP_W'(MAX_FRAMES) : CMP_W'(frame_limit);

  assign seen[0] = 1'b0;
  assign found   = seen[MAX_FRAMES];

  assign insert   = !found && (CMP_W'(occ_eff) < lim);
  assign evict    = !found && !insert;
  assign occ_last = occ_eff - OCC_W'(1);
  assign top      = insert ? occ_eff : occ_last;

  assign ctrl.upd        = pend;
  assign ctrl.found      = found;
  assign ctrl.miss_shift = !found && (insert || (occ_eff != '0));

  // Least recent resident page; empty stack evicts the key itself
  assign victim = (occ_eff == '0) ? key : pages[occ_last[IDX_W-1:0]];

  assign fault_new = found ? fault_base :
                     ((fault_base == COUNT_MAX) ? fault_base : fault_base + COUNT_W'(1));
  assign occ_next  = insert ? occ_eff + OCC_W'(1) : occ_eff;

  always_comb begin
    rsp_next.hit           = found;
    rsp_next.fault_count   = fault_new;
    rsp_next.evicted_valid = evict;
    rsp_next.evicted_page  = evict ? PAGE_FIELD_W'(victim) : '0;
  end

  // Row of cells, front is most recent
  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    if (i == 0) begin : g_front
      assign lefts[i] = key;
    end else begin : g_rest
      assign lefts[i] = pages[i-1];
    end

    lrupr_cell #(
      .PAGE_BITS (PAGE_BITS),
      .OCC_W     (OCC_W),
      .IDX       (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (occ_eff),
      .top       (top),
      .key       (key),
      .left_page (lefts[i]),
      .seen_in   (seen[i]),
      .page      (pages[i]),
      .seen_out  (seen[i+1])
    );
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pend        <= 1'b0;
      done        <= 1'b0;
      occ         <= '0;
      faults      <= '0;
      frame_limit <= FRAME_LIMIT_RST;
    end else begin
      pend <= start && !pend;
      done <= pend;
      if (pend) begin
        occ    <= occ_next;
        faults <= fault_new;
      end
      if (cfg_we) begin
        frame_limit <= cfg_data;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (start && !pend) begin
      key     <= PAGE_BITS'(req.page_number);
      first_q <= req.first_of_run;
    end
    if (pend) begin
      rsp <= rsp_next;
    end
  end

endmodule

@@ sv/lrupr_cell.sv @@
// One position of the recency stack: holds a page, compares and shifts.
module lrupr_cell
  import lrupr_pkg::*;
#(
  parameter int PAGE_BITS = PAGE_BITS_DEF,
  parameter int OCC_W     = 6,
  parameter int IDX       = 0
) (
  input  logic                 clk,
  input  lrupr_cell_ctrl_t     ctrl,
  input  logic [OCC_W-1:0]     occ,       // resident pages at start of access
  input  logic [OCC_W-1:0]     top,       // last position that takes a shift
  input  logic [PAGE_BITS-1:0] key,
  input  logic [PAGE_BITS-1:0] left_page, // neighbor toward the front
  input  logic                 seen_in,   // match in a cell toward the front
  output logic [PAGE_BITS-1:0] page,
  output logic                 seen_out
);

  localparam logic [OCC_W-1:0] MY_IDX = OCC_W'(IDX);

  logic valid;
  logic match;
  logic shift;

  // Occupied positions are the front occ entries
  assign valid    = MY_IDX < occ;
  assign match    = valid && (page == key);
  assign seen_out = seen_in | match;

  // Hit: cells up to the match shift; miss: cells up to top shift
  always_comb begin
    if (ctrl.found) begin
      shift = ctrl.upd && !seen_in;
    end else begin
      shift = ctrl.upd && ctrl.miss_shift && (MY_IDX <= top);
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      page <= left_page;
    end
  end

endmodule

@@ bench/lru_page_replacement_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for lru_page_replacement: queued page references, inline LRU predictor.
module lru_page_replacement_test;
  import lrupr_pkg::*;

  localparam int NUM_FRAMES    = MAX_FRAMES_DEF;
  localparam int RUN_LIMIT     = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_REFS   = 1450;
  localparam int SHOW_ERRORS   = 10;

  typedef enum logic {OP_ACCESS, OP_SET_LIMIT} op_kind_t;

  typedef struct {
    op_kind_t           kind;
    lrupr_req_t         req;
    logic [LIMIT_W-1:0] limit;
    int unsigned        gap;
  } stim_op_t;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               start    = 1'b0;
  logic               busy;
  lrupr_req_t         req      = '0;
  logic               done;
  lrupr_rsp_t         rsp;
  logic               cfg_we   = 1'b0;
  logic [LIMIT_W-1:0] cfg_data = '0;

  // Stimulus and expectation stores
  stim_op_t   op_q[$];
  lrupr_rsp_t due_rsp[$];

  // Predictor state: recency-ordered pages, most recent at index 0
  logic [PAGE_FIELD_W-1:0] resident [NUM_FRAMES];
  int unsigned             n_resident    = 0;
  logic [COUNT_W-1:0]      faults_in_run = '0;
  logic [LIMIT_W-1:0]      frames_cfg    = FRAME_LIMIT_RST;

  int unsigned err_cnt      = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned gap_left     = 0;
  int unsigned quiet_cycles = 0;

  lru_page_replacement u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .done     (done),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Shift the first count entries back by one and put pg in front
  task automatic shift_in_page(input int unsigned count, input logic [PAGE_FIELD_W-1:0] pg);
    for (int i = NUM_FRAMES - 1; i > 0; i--) begin
      if (i <= count) resident[i] = resident[i-1];
    end
    resident[0] = pg;
  endtask

  // Expected response of one page reference; updates the predictor state
  task automatic lru_access(input lrupr_req_t a, output lrupr_rsp_t r);
    int unsigned             lim;
    int unsigned             pos;
    bit                      found;
    logic [PAGE_FIELD_W-1:0] pg;
    pg    = a.page_number;
    lim   = (frames_cfg > NUM_FRAMES) ? NUM_FRAMES : frames_cfg;
    r     = '0;
    found = 1'b0;
    pos   = 0;
    if (a.first_of_run) begin
      n_resident    = 0;
      faults_in_run = '0;
    end
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (!found && i < n_resident && resident[i] == pg) begin
        found = 1'b1;
        pos   = i;
      end
    end
    if (found) begin
      shift_in_page(pos, pg);
      r.hit = 1'b1;
    end else begin
      if (faults_in_run != COUNT_MAX) faults_in_run++;
      if (n_resident < lim) begin
        shift_in_page(n_resident, pg);
        n_resident++;
      end else if (n_resident == 0) begin
        // zero frames: the page goes straight back out
        r.evicted_valid = 1'b1;
        r.evicted_page  = pg;
      end else begin
        r.evicted_valid = 1'b1;
        r.evicted_page  = resident[n_resident-1];
        shift_in_page(n_resident - 1, pg);
      end
    end
    r.fault_count = faults_in_run;
  endtask

  // Gap after an operation: mostly none or short, now and then long
  function automatic int unsigned draw_gap(input bit gaps_on);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_access(input logic [PAGE_FIELD_W-1:0] pg, input bit first,
                            input int unsigned gap);
    stim_op_t op;
    op.kind             = OP_ACCESS;
    op.req.page_number  = pg;
    op.req.first_of_run = first;
    op.limit            = '0;
    op.gap              = gap;
    op_q = {op_q, op};
  endtask

  task automatic add_limit(input logic [LIMIT_W-1:0] lim);
    stim_op_t op;
    op.kind  = OP_SET_LIMIT;
    op.req   = '0;
    op.limit = lim;
    op.gap   = 0;
    op_q = {op_q, op};
  endtask

  // Driver: one transaction or limit write at a time, limit writes only when idle
  always @(posedge clk) begin
    logic       nxt_start;
    logic       nxt_we;
    lrupr_rsp_t want;
    stim_op_t   op;
    if (rst) begin
      start  <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      nxt_start = start;
      nxt_we    = 1'b0;
      if (start && !busy) begin
        lru_access(req, want);
        due_rsp = {due_rsp, want};
        nxt_start = 1'b0;
      end
      if (nxt_start || due_rsp.size() != 0) quiet_cycles = 0;
      else quiet_cycles++;
      if (!nxt_start && !cfg_we) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (op_q.size() != 0) begin
          if (op_q[0].kind == OP_ACCESS) begin
            op        = op_q[0];
            op_q.delete(0);
            req      <= op.req;
            nxt_start = 1'b1;
            gap_left  = op.gap;
          end else if (quiet_cycles >= SETTLE_CYCLES) begin
            op         = op_q[0];
            op_q.delete(0);
            cfg_data  <= op.limit;
            nxt_we     = 1'b1;
            frames_cfg = op.limit;
            gap_left   = op.gap;
          end
        end
      end
      start  <= nxt_start;
      cfg_we <= nxt_we;
    end
  end

  // Monitor: every done cycle carries one result, checked against the oldest expectation
  always @(posedge clk) begin
    lrupr_rsp_t want;
    if (!rst && done) begin
      if (due_rsp.size() == 0) begin
        err_cnt++;
        if (err_cnt <= SHOW_ERRORS)
          $display("%0t: result with nothing expected: hit=%0b faults=%0d ev=%0b page=%h",
                   $realtime, rsp.hit, rsp.fault_count, rsp.evicted_valid, rsp.evicted_page);
      end else begin
        want = due_rsp[0];
        due_rsp.delete(0);
        if (rsp.hit !== want.hit || rsp.fault_count !== want.fault_count ||
            rsp.evicted_valid !== want.evicted_valid ||
            rsp.evicted_page !== want.evicted_page) begin
          err_cnt++;
          if (err_cnt <= SHOW_ERRORS)
            $display({"%0t: mismatch exp hit=%0b faults=%0d ev=%0b page=%h",
                      " / got hit=%0b faults=%0d ev=%0b page=%h"},
                     $realtime, want.hit, want.fault_count, want.evicted_valid,
                     want.evicted_page, rsp.hit, rsp.fault_count, rsp.evicted_valid,
                     rsp.evicted_page);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= RUN_LIMIT) begin
      $display("lru_page_replacement_test failed");
      $finish;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    logic [PAGE_FIELD_W-1:0] pool [40];
    int unsigned             n_refs;
    int unsigned             pool_n;
    int unsigned             lim_eff;
    int unsigned             phase_len;
    int unsigned             sel;
    logic [LIMIT_W-1:0]      lim;
    bit                      gaps_on;

    // full frames after reset: extremes of the page field, a hit, a repeat hit
    add_access(16'h0000, 1'b1, 0);
    add_access(16'hFFFF, 1'b0, 0);
    add_access(16'h0000, 1'b0, 2);
    add_access(16'h5A5A, 1'b0, 0);
    add_access(16'hFFFF, 1'b0, 0);
    // no frames: each fault evicts the page just referenced
    add_limit(6'd0);
    add_access(16'h1234, 1'b1, 0);
    add_access(16'h1234, 1'b0, 0);
    add_access(16'hFFFF, 1'b0, 1);
    // two frames: plain LRU eviction
    add_limit(6'd2);
    add_access(16'hA5A5, 1'b1, 0);
    add_access(16'h0B0B, 1'b0, 0);
    add_access(16'hA5A5, 1'b0, 0);
    add_access(16'h0C0C, 1'b0, 0);
    add_access(16'h0B0B, 1'b0, 0);
    // four frames filled, then the limit drops to one mid-run
    add_limit(6'd4);
    add_access(16'h0001, 1'b1, 0);
    add_access(16'h0002, 1'b0, 0);
    add_access(16'h0003, 1'b0, 0);
    add_access(16'h0004, 1'b0, 0);
    add_limit(6'd1);
    add_access(16'h0002, 1'b0, 0);
    add_access(16'h0005, 1'b0, 0);
    add_access(16'h0003, 1'b0, 0);
    add_access(16'h0006, 1'b0, 0);
    // limit above the frame count is clamped
    add_limit(6'd63);
    add_access(16'h8000, 1'b1, 0);
    add_access(16'h7FFF, 1'b0, 0);

    // random phases: a limit, then references drawn mostly from a small working set
    n_refs = 0;
    while (n_refs < RANDOM_REFS) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) lim = 6'd0;
      else if (sel == 1) lim = 6'd32;
      else if (sel == 2) lim = LIMIT_W'($urandom_range(33, 63));
      else lim = LIMIT_W'($urandom_range(1, 32));
      add_limit(lim);
      lim_eff   = (lim > NUM_FRAMES) ? NUM_FRAMES : lim;
      pool_n    = $urandom_range(1, lim_eff + 6);
      gaps_on   = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(20, 90);
      for (int i = 0; i < pool_n; i++) pool[i] = PAGE_FIELD_W'($urandom_range(0, 65535));
      for (int i = 0; i < phase_len; i++) begin
        sel = $urandom_range(0, 99);
        add_access((sel < 85) ? pool[$urandom_range(0, pool_n - 1)]
                              : PAGE_FIELD_W'($urandom_range(0, 65535)),
                   (i == 0) ? bit'($urandom_range(0, 1)) : ($urandom_range(0, 49) == 0),
                   draw_gap(gaps_on));
        n_refs++;
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (op_q.size() != 0 || start || cfg_we || due_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0 && due_rsp.size() == 0) begin
      $display("lru_page_replacement_test passed");
    end else begin
      $display("lru_page_replacement_test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/lrupr_pkg.sv
sv/lrupr_cell.sv
sv/lru_page_replacement.sv
bench/lru_page_replacement_test.sv
